>>> design/msc_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and helper functions for the magic square cipher
// no dependencies

package msc_pkg;

  localparam int SIDE   = 16;
  localparam int LW     = $clog2(SIDE);
  localparam int AW     = 2 * LW;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int DW     = 8;
  localparam int FUNC_W = 3;

  localparam logic [LW-1:0] Q1 = LW'(SIDE / 4);
  localparam logic [LW-1:0] Q3 = LW'(3 * (SIDE / 4));

  localparam logic [DW-1:0] CH_0 = 8'h30;
  localparam logic [DW-1:0] CH_1 = 8'h31;
  localparam logic [DW-1:0] CH_9 = 8'h39;

  typedef enum logic [FUNC_W-1:0] {
    FN_RESTORE  = 3'd0,
    FN_SWAP_ROW = 3'd1,
    FN_SWAP_COL = 3'd2,
    FN_ENCRYPT  = 3'd3,
    FN_DECRYPT  = 3'd4
  } func_t;

  // digit group status toward the sequencer
  typedef struct packed {
    logic          full;
    logic          ok;
    logic [AW-1:0] addr;
  } grp_t;

  // square entry at flat index k after a restore, mod 256
  function automatic logic [DW-1:0] fill_value(input logic [AW-1:0] k);
    logic [LW-1:0] r;
    logic [LW-1:0] c;
    logic          r_edge;
    logic          c_edge;
    logic          flip;
    r      = k[AW-1:LW];
    c      = k[LW-1:0];
    r_edge = (r < Q1) || (r >= Q3);
    c_edge = (c < Q1) || (c >= Q3);
    flip   = (r_edge && c_edge) || (!r_edge && !c_edge);
    if (flip) begin
      fill_value = DW'(DEPTH - int'(k));
    end else begin
      fill_value = DW'(int'(k) + 1);
    end
  endfunction

  // two ascii digits to an index below SIDE, msb flags a valid pair
  function automatic logic [LW:0] two_digits(input logic [DW-1:0] hi,
                                             input logic [DW-1:0] lo);
    logic       lo_dig;
    logic [3:0] lv;
    logic [4:0] ten_up;
    lo_dig = (lo >= CH_0) && (lo <= CH_9);
    lv     = lo[3:0];
    ten_up = {1'b0, lv} + 5'd10;
    two_digits = '0;
    if (lo_dig && hi == CH_0 && {1'b0, lv} < 5'(SIDE)) begin
      two_digits = {1'b1, lv[LW-1:0]};
    end else if (lo_dig && hi == CH_1 && ten_up < 5'(SIDE)) begin
      two_digits = {1'b1, ten_up[LW-1:0]};
    end
  endfunction

  // index below SIDE to two ascii digits, tens in the upper byte
  function automatic logic [2*DW-1:0] to_digits(input logic [LW-1:0] n);
    logic [4:0] v;
    logic [4:0] u;
    v = 5'(n);
    u = (v >= 5'd10) ? v - 5'd10 : v;
    to_digits = {((v >= 5'd10) ? CH_1 : CH_0), CH_0 + DW'(u)};
  endfunction

endpackage

>>> design/msc_if.sv
`timescale 1ns / 1ps
// request and result channel interfaces of the magic square cipher
// depends on msc_pkg

interface msc_req_if;
  logic                          valid;
  logic                          ready;
  logic [msc_pkg::FUNC_W-1:0]    func;
  logic [msc_pkg::LW-1:0]        line;
  logic [msc_pkg::DW-1:0]        data_char;
  logic                          end_of_text;

  modport source (output valid, func, line, data_char, end_of_text, input ready);
  modport sink   (input valid, func, line, data_char, end_of_text, output ready);
endinterface

interface msc_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [msc_pkg::DW-1:0]   out_char;
  logic                     last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

>>> design/magic_square_substitution_cipher.sv
`timescale 1ns / 1ps
// top level of the magic square cipher: sequencer, square and inverse memories
// depends on msc_pkg, msc_if, msc_ram, msc_digits
//
//   channel | dir | payload                              | handshake
//   req     | in  | func, line, data_char, end_of_text   | valid / ready
//   rsp     | out | out_char, last                       | valid / ready
//
// the square and its inverse live in two 256 x 8 rams with registered reads
// encrypt: the inverse is read as the request is taken and captured in grab, then 4 results
// decrypt: a buffered character is taken in idle, the one closing a group passes grab and emit
// swap: 16 pairs, each in 4 ram steps (read a, read b, write a, write b)
// reset and restore refill both rams one entry a cycle, no request taken
// a stalled result only holds the output register; new requests wait in emit

module magic_square_substitution_cipher (
  input  logic            clk,
  input  logic            rst,
  msc_req_if.sink         req,
  msc_rsp_if.source       rsp
);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SWAP,
    ST_GRAB,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    SW_RDA,
    SW_RDB,
    SW_WRA,
    SW_WRB
  } swp_t;

  state_t                  state;
  swp_t                    phase;
  logic [msc_pkg::AW-1:0]  idx;
  logic [msc_pkg::LW-1:0]  k;
  logic [msc_pkg::LW-1:0]  x;
  logic                    rows;
  logic [msc_pkg::DW-1:0]  va;
  logic                    enc;
  logic                    ok;
  logic [msc_pkg::DW-1:0]  hold;
  logic [1:0]              cnt;

  logic                    acc;
  msc_pkg::grp_t           grp;
  logic [msc_pkg::AW-1:0]  a_addr;
  logic [msc_pkg::AW-1:0]  b_addr;
  logic [msc_pkg::DW-1:0]  fv;
  logic [2*msc_pkg::DW-1:0] row_dig;
  logic [2*msc_pkg::DW-1:0] col_dig;
  logic [msc_pkg::DW-1:0]  enc_char;

  logic                    sq_we;
  logic [msc_pkg::AW-1:0]  sq_waddr;
  logic [msc_pkg::DW-1:0]  sq_wdata;
  logic [msc_pkg::AW-1:0]  sq_raddr;
  logic [msc_pkg::DW-1:0]  sq_rdata;
  logic                    pos_we;
  logic [msc_pkg::AW-1:0]  pos_waddr;
  logic [msc_pkg::AW-1:0]  pos_wdata;
  logic [msc_pkg::DW-1:0]  pos_rdata;

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;

  msc_digits u_digits (
    .clk  (clk),
    .rst  (rst),
    .load (acc && req.func == msc_pkg::FN_DECRYPT),
    .ch   (req.data_char),
    .eot  (req.end_of_text),
    .grp  (grp)
  );

  msc_ram #(.WIDTH(msc_pkg::DW), .DEPTH(msc_pkg::DEPTH)) u_square (
    .clk   (clk),
    .we    (sq_we),
    .waddr (sq_waddr),
    .wdata (sq_wdata),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  msc_ram #(.WIDTH(msc_pkg::DW), .DEPTH(msc_pkg::DEPTH)) u_position (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (req.data_char),
    .rdata (pos_rdata)
  );

  assign a_addr = rows ? {x, k} : {k, x};
  assign b_addr = rows ? {~x, k} : {k, ~x};
  assign fv     = msc_pkg::fill_value(idx);

  always_comb begin
    sq_raddr  = grp.addr;
    sq_we     = 1'b0;
    sq_waddr  = idx;
    sq_wdata  = fv;
    pos_we    = 1'b0;
    pos_waddr = fv;
    pos_wdata = idx;
    if (state == ST_FILL) begin
      sq_we  = 1'b1;
      pos_we = 1'b1;
    end else if (state == ST_SWAP) begin
      sq_raddr = (phase == SW_RDA) ? a_addr : b_addr;
      if (phase == SW_WRA) begin
        // b's value moves to a
        sq_we     = 1'b1;
        sq_waddr  = a_addr;
        sq_wdata  = sq_rdata;
        pos_we    = 1'b1;
        pos_waddr = sq_rdata;
        pos_wdata = a_addr;
      end else if (phase == SW_WRB) begin
        sq_we     = 1'b1;
        sq_waddr  = b_addr;
        sq_wdata  = va;
        pos_we    = 1'b1;
        pos_waddr = va;
        pos_wdata = b_addr;
      end
    end
  end

  assign row_dig = msc_pkg::to_digits(hold[msc_pkg::AW-1:msc_pkg::LW]);
  assign col_dig = msc_pkg::to_digits(hold[msc_pkg::LW-1:0]);

  always_comb begin
    unique case (cnt)
      2'd0:    enc_char = row_dig[2*msc_pkg::DW-1:msc_pkg::DW];
      2'd1:    enc_char = row_dig[msc_pkg::DW-1:0];
      2'd2:    enc_char = col_dig[2*msc_pkg::DW-1:msc_pkg::DW];
      default: enc_char = col_dig[msc_pkg::DW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      idx       <= '0;
      phase     <= SW_RDA;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // emit handles its own valid
      if (rsp.valid && rsp.ready && state != ST_EMIT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_FILL: begin
          idx <= idx + 1'b1;
          if (idx == msc_pkg::AW'(msc_pkg::DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            unique case (msc_pkg::func_t'(req.func))
              msc_pkg::FN_RESTORE: begin
                idx   <= '0;
                state <= ST_FILL;
              end
              msc_pkg::FN_SWAP_ROW, msc_pkg::FN_SWAP_COL: begin
                rows  <= (req.func == msc_pkg::FN_SWAP_ROW);
                x     <= req.line;
                k     <= '0;
                phase <= SW_RDA;
                state <= ST_SWAP;
              end
              msc_pkg::FN_ENCRYPT: begin
                enc   <= 1'b1;
                state <= ST_GRAB;
              end
              msc_pkg::FN_DECRYPT: begin
                if (grp.full) begin
                  enc   <= 1'b0;
                  ok    <= grp.ok;
                  state <= ST_GRAB;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SWAP: begin
          unique case (phase)
            SW_RDA: phase <= SW_RDB;
            SW_RDB: begin
              va    <= sq_rdata;
              phase <= SW_WRA;
            end
            SW_WRA: phase <= SW_WRB;
            default: begin
              phase <= SW_RDA;
              k     <= k + 1'b1;
              if (k == msc_pkg::LW'(msc_pkg::SIDE - 1)) begin
                state <= ST_IDLE;
              end
            end
          endcase
        end
        ST_GRAB: begin
          if (enc) begin
            hold <= pos_rdata;
          end else begin
            hold <= ok ? sq_rdata : '0;
          end
          cnt   <= '0;
          state <= ST_EMIT;
        end
        default: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            if (enc) begin
              rsp.out_char <= enc_char;
              rsp.last     <= (cnt == 2'd3);
              cnt          <= cnt + 2'd1;
              if (cnt == 2'd3) begin
                state <= ST_IDLE;
              end
            end else begin
              rsp.out_char <= hold;
              rsp.last     <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

endmodule

>>> design/msc_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with one registered read port
// no dependencies

module msc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/msc_digits.sv
`timescale 1ns / 1ps
// ciphertext digit collector: buffers up to three characters and checks a group
// depends on msc_pkg

module msc_digits (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [msc_pkg::DW-1:0]  ch,
  input  logic                    eot,
  output msc_pkg::grp_t           grp
);

  logic [msc_pkg::DW-1:0] digit_buffer [3];
  logic [1:0]             digit_count;
  logic [msc_pkg::LW:0]   row_dec;
  logic [msc_pkg::LW:0]   col_dec;

  assign row_dec  = msc_pkg::two_digits(digit_buffer[0], digit_buffer[1]);
  assign col_dec  = msc_pkg::two_digits(digit_buffer[2], ch);
  assign grp.full = (digit_count == 2'd3);
  assign grp.ok   = row_dec[msc_pkg::LW] && col_dec[msc_pkg::LW];
  assign grp.addr = {row_dec[msc_pkg::LW-1:0], col_dec[msc_pkg::LW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count     <= '0;
      digit_buffer[0] <= '0;
      digit_buffer[1] <= '0;
      digit_buffer[2] <= '0;
    end else if (load) begin
      if (digit_count == 2'd3) begin
        digit_count <= '0;
      end else begin
        digit_buffer[digit_count] <= ch;
        // end of text drops a partial group
        digit_count <= eot ? 2'd0 : digit_count + 2'd1;
      end
    end
  end

endmodule
